### rtl/mlso_pkg.sv
// ----------------------------------------------------------------------------
// mlso_pkg
// Shared types, constants and the format decode for the mip level size and
// offset unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mlso_pkg;

  localparam int unsigned CLASS_W    = 3;
  localparam int unsigned DIM_W      = 16;
  localparam int unsigned LVL_W      = 5;
  localparam int unsigned BYTES_W    = 35;
  localparam int unsigned PROD_W     = 2 * DIM_W;
  localparam int unsigned MIN_W      = 6;
  localparam int unsigned MAX_LEVELS = 16;

  // Format class codes
  localparam logic [CLASS_W-1:0] FMT_RGBA32 = 3'd0;
  localparam logic [CLASS_W-1:0] FMT_RGB24  = 3'd1;
  localparam logic [CLASS_W-1:0] FMT_16BPP  = 3'd2;
  localparam logic [CLASS_W-1:0] FMT_8BPP   = 3'd3;
  localparam logic [CLASS_W-1:0] FMT_BC8    = 3'd4;
  localparam logic [CLASS_W-1:0] FMT_BC16   = 3'd5;
  localparam logic [CLASS_W-1:0] FMT_PVRTC2 = 3'd6;
  localparam logic [CLASS_W-1:0] FMT_PVRTC4 = 3'd7;

  // Block bytes are (1 << byte_shift) plus one more copy when triple is set.
  typedef struct packed {
    logic [1:0]       w_shift;
    logic [1:0]       h_shift;
    logic [2:0]       byte_shift;
    logic             triple;
    logic [MIN_W-1:0] min_size;
  } fmt_desc_t;

  typedef struct packed {
    fmt_desc_t        desc;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [LVL_W-1:0] count;
  } item_t;

  function automatic fmt_desc_t decode_fmt(input logic [CLASS_W-1:0] fmt);
    fmt_desc_t d;
    d = '0;
    case (fmt)
      FMT_RGBA32: begin d.byte_shift = 3'd2; d.min_size = 6'd1; end
      FMT_RGB24:  begin d.byte_shift = 3'd1; d.triple = 1'b1; d.min_size = 6'd1; end
      FMT_16BPP:  begin d.byte_shift = 3'd1; d.min_size = 6'd1; end
      FMT_8BPP:   begin d.byte_shift = 3'd0; d.min_size = 6'd1; end
      FMT_BC8: begin
        d.w_shift = 2'd2; d.h_shift = 2'd2; d.byte_shift = 3'd3; d.min_size = 6'd8;
      end
      FMT_BC16: begin
        d.w_shift = 2'd2; d.h_shift = 2'd2; d.byte_shift = 3'd4; d.min_size = 6'd16;
      end
      FMT_PVRTC2: begin
        d.w_shift = 2'd3; d.h_shift = 2'd2; d.byte_shift = 3'd3; d.min_size = 6'd32;
      end
      FMT_PVRTC4: begin
        d.w_shift = 2'd2; d.h_shift = 2'd2; d.byte_shift = 3'd3; d.min_size = 6'd32;
      end
      default: begin d.byte_shift = 3'd0; d.min_size = 6'd1; end
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

### rtl/mlso_fifo.sv
// ----------------------------------------------------------------------------
// mlso_fifo
// Two-entry queue of decoded requests between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mlso_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire mlso_pkg::item_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output mlso_pkg::item_t    pop_data_o,
  output logic               empty_o
);

  mlso_pkg::item_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  cnt_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("queue count out of range");

  ptr_cnt_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

  no_push_full_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && push_i && !do_pop) |=> (cnt_q == 2'd2))
    else $error("queue overflow");

endmodule

`default_nettype wire

### rtl/mlso_front.sv
// ----------------------------------------------------------------------------
// mlso_front
// Accepts requests, decodes the format class, clamps the level count and
// queues the request for the back. Requests with no levels are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module mlso_front #(
  parameter int unsigned MAX_LEVELS = mlso_pkg::MAX_LEVELS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [mlso_pkg::CLASS_W-1:0]  format_class_i,
  input  wire logic [mlso_pkg::DIM_W-1:0]    base_width_i,
  input  wire logic [mlso_pkg::DIM_W-1:0]    base_height_i,
  input  wire logic [mlso_pkg::LVL_W-1:0]    level_count_i,
  output logic                               push_o,
  output mlso_pkg::item_t                    push_data_o,
  input  wire logic                          full_i
);

  localparam logic [mlso_pkg::LVL_W:0] MaxCnt = (mlso_pkg::LVL_W + 1)'(MAX_LEVELS);

  logic [mlso_pkg::LVL_W-1:0] cnt_clamped;

  always_comb begin
    if ({1'b0, level_count_i} > MaxCnt) begin
      cnt_clamped = MaxCnt[mlso_pkg::LVL_W-1:0];
    end else begin
      cnt_clamped = level_count_i;
    end
  end

  assign in_stall_o         = full_i;
  assign push_o             = in_valid_i && !full_i && (level_count_i != '0);
  assign push_data_o.desc   = mlso_pkg::decode_fmt(format_class_i);
  assign push_data_o.width  = base_width_i;
  assign push_data_o.height = base_height_i;
  assign push_data_o.count  = cnt_clamped;

  no_empty_push_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (push_data_o.count != '0))
    else $error("queued request with no levels");

  clamp_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> ({1'b0, push_data_o.count} <= MaxCnt))
    else $error("level count above limit");

  stall_full_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_i |-> !push_o)
    else $error("push while queue full");

endmodule

`default_nettype wire

### rtl/mlso_back.sv
// ----------------------------------------------------------------------------
// mlso_back
// Walks the mip levels of one request: a product stage forms the block count
// of each level, an output stage scales, clamps and accumulates it.
// ----------------------------------------------------------------------------
`default_nettype none

module mlso_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          empty_i,
  input  wire mlso_pkg::item_t               pop_data_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [mlso_pkg::BYTES_W-1:0]       level_offset_o,
  output logic [mlso_pkg::BYTES_W-1:0]       level_size_o,
  output logic [mlso_pkg::BYTES_W-1:0]       running_total_o,
  output logic                               is_last_o
);

  localparam int unsigned BW = mlso_pkg::BYTES_W;

  typedef logic [mlso_pkg::PROD_W-1:0] PROD_W_t;

  // level walker
  logic                        busy_q, busy_d;
  logic [mlso_pkg::DIM_W-1:0]  w_q, w_d, h_q, h_d;
  logic [mlso_pkg::LVL_W-1:0]  remain_q, remain_d;
  mlso_pkg::fmt_desc_t         desc_q, desc_d;

  // product stage
  logic                        p_valid_q, p_valid_d;
  logic                        p_last_q, p_last_d;
  logic [mlso_pkg::PROD_W-1:0] prod_q, prod_d;
  mlso_pkg::fmt_desc_t         p_desc_q, p_desc_d;

  // output stage
  logic                        out_valid_q, out_valid_d;
  logic                        out_last_q, out_last_d;
  logic [BW-1:0]               out_offset_q, out_offset_d;
  logic [BW-1:0]               out_size_q, out_size_d;
  logic [BW-1:0]               out_total_q, out_total_d;
  logic [BW-1:0]               total_q, total_d;

  logic                        adv, issue;
  logic [BW-1:0]               scaled, clamped;

  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = !busy_q && !empty_i;
  assign issue = busy_q && adv;

  always_comb begin
    scaled = ({{(BW - mlso_pkg::PROD_W){1'b0}}, prod_q} << p_desc_q.byte_shift)
           + (p_desc_q.triple ? {{(BW - mlso_pkg::PROD_W){1'b0}}, prod_q} : '0);
    if (scaled < BW'(p_desc_q.min_size)) begin
      clamped = BW'(p_desc_q.min_size);
    end else begin
      clamped = scaled;
    end
  end

  always_comb begin
    busy_d   = busy_q;
    w_d      = w_q;
    h_d      = h_q;
    remain_d = remain_q;
    desc_d   = desc_q;
    if (pop_o) begin
      busy_d   = 1'b1;
      w_d      = pop_data_i.width;
      h_d      = pop_data_i.height;
      remain_d = pop_data_i.count;
      desc_d   = pop_data_i.desc;
    end else if (issue) begin
      w_d      = w_q >> 1;
      h_d      = h_q >> 1;
      remain_d = remain_q - (mlso_pkg::LVL_W)'(1);
      busy_d   = (remain_q != 1);
    end
  end

  always_comb begin
    p_valid_d = p_valid_q;
    p_last_d  = p_last_q;
    prod_d    = prod_q;
    p_desc_d  = p_desc_q;
    if (adv) begin
      p_valid_d = busy_q;
      p_last_d  = (remain_q == 1);
      prod_d    = PROD_W_t'(w_q >> desc_q.w_shift) * PROD_W_t'(h_q >> desc_q.h_shift);
      p_desc_d  = desc_q;
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_last_d   = out_last_q;
    out_offset_d = out_offset_q;
    out_size_d   = out_size_q;
    out_total_d  = out_total_q;
    total_d      = total_q;
    if (adv) begin
      out_valid_d = p_valid_q;
      if (p_valid_q) begin
        out_last_d   = p_last_q;
        out_offset_d = total_q;
        out_size_d   = clamped;
        out_total_d  = total_q + clamped;
        total_d      = p_last_q ? '0 : (total_q + clamped);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      remain_q    <= '0;
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      busy_q      <= busy_d;
      remain_q    <= remain_d;
      p_valid_q   <= p_valid_d;
      out_valid_q <= out_valid_d;
      total_q     <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q          <= w_d;
    h_q          <= h_d;
    desc_q       <= desc_d;
    p_last_q     <= p_last_d;
    prod_q       <= prod_d;
    p_desc_q     <= p_desc_d;
    out_last_q   <= out_last_d;
    out_offset_q <= out_offset_d;
    out_size_q   <= out_size_d;
    out_total_q  <= out_total_d;
  end

  assign out_valid_o     = out_valid_q;
  assign level_offset_o  = out_offset_q;
  assign level_size_o    = out_size_q;
  assign running_total_o = out_total_q;
  assign is_last_o       = out_last_q;

  busy_remain_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (remain_q != '0))
    else $error("walker busy with no levels left");

  last_issue_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && remain_q == 1) |=> !busy_q)
    else $error("walker still busy after last level");

  total_sum_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_total_q == out_offset_q + out_size_q))
    else $error("running total does not match offset plus size");

  accum_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && p_valid_q) |=> (out_last_q ? (total_q == '0) : (total_q == out_total_q)))
    else $error("accumulator out of step with output");

endmodule

`default_nettype wire

### rtl/mip_level_size_offset_unit.sv
// ----------------------------------------------------------------------------
// mip_level_size_offset_unit
// Byte layout of a texture mipmap chain: offset, size and running total of
// every level.
// ----------------------------------------------------------------------------
// Input channel: one request carries a format class, base width, base height
// and level count. It is taken when in_valid_i is high and in_stall_o low.
// A request with a level count of zero produces no result; counts above
// MAX_LEVELS are limited to MAX_LEVELS.
// Output channel: one result per level, level zero first, with is_last_o set
// on the final one. A result is taken when out_valid_o is high and
// out_stall_i low; while out_stall_i is high with a result pending, the
// output holds and the level walker and product stage freeze.
// The first result of a request leaves the output stage, after the queue,
// the level walker and the product stage registers.
// The level walker loads a request from the queue, then issues one level per
// cycle while the output is not stalled. A two-entry queue behind the
// format decoder takes further requests while the walker is busy.
// Reset empties the queue and all pipeline stages; no result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module mip_level_size_offset_unit #(
  parameter int unsigned MAX_LEVELS = mlso_pkg::MAX_LEVELS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [mlso_pkg::CLASS_W-1:0]  format_class_i,
  input  wire logic [mlso_pkg::DIM_W-1:0]    base_width_i,
  input  wire logic [mlso_pkg::DIM_W-1:0]    base_height_i,
  input  wire logic [mlso_pkg::LVL_W-1:0]    level_count_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [mlso_pkg::BYTES_W-1:0]       level_offset_o,
  output logic [mlso_pkg::BYTES_W-1:0]       level_size_o,
  output logic [mlso_pkg::BYTES_W-1:0]       running_total_o,
  output logic                               is_last_o
);

  logic            push, full, pop, empty;
  mlso_pkg::item_t push_data, pop_data;

  mlso_front #(
    .MAX_LEVELS(MAX_LEVELS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .format_class_i(format_class_i),
    .base_width_i  (base_width_i),
    .base_height_i (base_height_i),
    .level_count_i (level_count_i),
    .push_o        (push),
    .push_data_o   (push_data),
    .full_i        (full)
  );

  mlso_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .empty_o    (empty)
  );

  mlso_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .pop_data_i     (pop_data),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .level_offset_o (level_offset_o),
    .level_size_o   (level_size_o),
    .running_total_o(running_total_o),
    .is_last_o      (is_last_o)
  );

endmodule

`default_nettype wire

### sim/tb_mip_level_size_offset_unit.sv
// ----------------------------------------------------------------------------
// tb_mip_level_size_offset_unit
// Self-checking bench for the mip level size and offset unit. A table of
// directed requests covers every format class, the dimension extremes, zero
// and saturated level counts; random requests follow under random idling on
// both channels. Each result is compared against a chain layout predictor.
// ----------------------------------------------------------------------------
module tb_mip_level_size_offset_unit;

  localparam int unsigned CLASS_W = mlso_pkg::CLASS_W;
  localparam int unsigned DIM_W   = mlso_pkg::DIM_W;
  localparam int unsigned LVL_W   = mlso_pkg::LVL_W;
  localparam int unsigned BYTES_W = mlso_pkg::BYTES_W;

  localparam int LEVEL_CAP      = 16;
  localparam int N_DIRECTED     = 22;
  localparam int RAND_ITEMS     = 388;
  localparam int HOLD_AT        = 120;
  localparam int PAUSE_AT       = 250;
  localparam int CALM_ITEMS     = 60;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [BYTES_W-1:0] offset;
    logic [BYTES_W-1:0] size;
    logic [BYTES_W-1:0] total;
    logic               last;
  } level_exp_t;

  typedef struct packed {
    logic [CLASS_W-1:0] fmt;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [LVL_W-1:0]   count;
    logic               typed;
    logic [BYTES_W-1:0] size0;
    logic [BYTES_W-1:0] total;
  } stim_row_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic [CLASS_W-1:0] format_class_i = '0;
  logic [DIM_W-1:0]   base_width_i   = '0;
  logic [DIM_W-1:0]   base_height_i  = '0;
  logic [LVL_W-1:0]   level_count_i  = '0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic [BYTES_W-1:0] level_offset_o;
  logic [BYTES_W-1:0] level_size_o;
  logic [BYTES_W-1:0] running_total_o;
  logic               is_last_o;

  level_exp_t levels_due[$];
  int         err_cnt          = 0;
  int         n_requests       = 0;
  int         n_zero_count     = 0;
  int         n_saturated      = 0;
  int         n_levels_checked = 0;
  int         idle_cycles      = 0;
  int         gap_pct          = 0;
  int         stall_pct        = 0;
  bit         long_hold_req    = 1'b0;

  // Typed rows carry the level zero size and the whole chain size.
  stim_row_t dir_rows [N_DIRECTED] = '{
    '{mlso_pkg::FMT_RGBA32, 16'd65535, 16'd65535, 5'd1,  1'b1,
      35'd17179344900, 35'd17179344900},
    '{mlso_pkg::FMT_RGB24,  16'd1,     16'd1,     5'd1,  1'b1, 35'd3,  35'd3},
    '{mlso_pkg::FMT_16BPP,  16'd0,     16'd0,     5'd1,  1'b1, 35'd1,  35'd1},
    '{mlso_pkg::FMT_8BPP,   16'd0,     16'd65535, 5'd1,  1'b1, 35'd1,  35'd1},
    '{mlso_pkg::FMT_BC8,    16'd0,     16'd0,     5'd1,  1'b1, 35'd8,  35'd8},
    '{mlso_pkg::FMT_BC16,   16'd4,     16'd4,     5'd1,  1'b1, 35'd16, 35'd16},
    '{mlso_pkg::FMT_PVRTC2, 16'd8,     16'd4,     5'd1,  1'b1, 35'd32, 35'd32},
    '{mlso_pkg::FMT_PVRTC4, 16'd3,     16'd3,     5'd1,  1'b1, 35'd32, 35'd32},
    '{mlso_pkg::FMT_RGBA32, 16'd1,     16'd1,     5'd16, 1'b1, 35'd4,  35'd19},
    '{mlso_pkg::FMT_8BPP,   16'd1,     16'd1,     5'd0,  1'b0, 35'd0,  35'd0},
    '{mlso_pkg::FMT_BC16,   16'd65535, 16'd65535, 5'd16, 1'b0, 35'd0,  35'd0},
    '{mlso_pkg::FMT_RGBA32, 16'd65535, 16'd65535, 5'd31, 1'b0, 35'd0,  35'd0},
    '{mlso_pkg::FMT_RGB24,  16'd65535, 16'd65535, 5'd17, 1'b0, 35'd0,  35'd0},
    '{mlso_pkg::FMT_PVRTC2, 16'd65535, 16'd0,     5'd5,  1'b0, 35'd0,  35'd0},
    '{mlso_pkg::FMT_BC8,    16'd256,   16'd256,   5'd9,  1'b0, 35'd0,  35'd0},
    '{mlso_pkg::FMT_16BPP,  16'd1024,  16'd1,     5'd11, 1'b0, 35'd0,  35'd0},
    '{mlso_pkg::FMT_PVRTC4, 16'd65535, 16'd65535, 5'd16, 1'b0, 35'd0,  35'd0},
    '{mlso_pkg::FMT_PVRTC2, 16'd65535, 16'd65535, 5'd16, 1'b0, 35'd0,  35'd0},
    '{mlso_pkg::FMT_8BPP,   16'd0,     16'd0,     5'd0,  1'b0, 35'd0,  35'd0},
    '{mlso_pkg::FMT_BC16,   16'd3,     16'd65535, 5'd2,  1'b1, 35'd16, 35'd32},
    '{mlso_pkg::FMT_8BPP,   16'd65535, 16'd65535, 5'd16, 1'b0, 35'd0,  35'd0},
    '{mlso_pkg::FMT_16BPP,  16'd32768, 16'd32768, 5'd16, 1'b0, 35'd0,  35'd0}
  };

  mip_level_size_offset_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .format_class_i  (format_class_i),
    .base_width_i    (base_width_i),
    .base_height_i   (base_height_i),
    .level_count_i   (level_count_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .level_offset_o  (level_offset_o),
    .level_size_o    (level_size_o),
    .running_total_o (running_total_o),
    .is_last_o       (is_last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Append the layout of every level of one chain; return the level count.
  function automatic int mip_chain_layout(input logic [CLASS_W-1:0] fmt,
                                          input logic [DIM_W-1:0] w0,
                                          input logic [DIM_W-1:0] h0,
                                          input logic [LVL_W-1:0] cnt);
    longint unsigned w, h, bw, bh, bpb, floor_sz, sz, acc;
    int n;
    level_exp_t e;
    w = w0;
    h = h0;
    acc = 0;
    bw = 1;
    bh = 1;
    bpb = 1;
    floor_sz = 1;
    case (fmt)
      mlso_pkg::FMT_RGBA32: bpb = 4;
      mlso_pkg::FMT_RGB24:  bpb = 3;
      mlso_pkg::FMT_16BPP:  bpb = 2;
      mlso_pkg::FMT_8BPP:   bpb = 1;
      mlso_pkg::FMT_BC8:    begin bw = 4; bh = 4; bpb = 8;  floor_sz = 8;  end
      mlso_pkg::FMT_BC16:   begin bw = 4; bh = 4; bpb = 16; floor_sz = 16; end
      mlso_pkg::FMT_PVRTC2: begin bw = 8; bh = 4; bpb = 8;  floor_sz = 32; end
      mlso_pkg::FMT_PVRTC4: begin bw = 4; bh = 4; bpb = 8;  floor_sz = 32; end
      default:              bpb = 1;
    endcase
    n = (int'(cnt) > LEVEL_CAP) ? LEVEL_CAP : int'(cnt);
    for (int k = 0; k < n; k++) begin
      sz = (w / bw) * (h / bh) * bpb;
      if (sz < floor_sz) sz = floor_sz;
      e.offset = acc[BYTES_W-1:0];
      e.size   = sz[BYTES_W-1:0];
      acc += sz;
      e.total  = acc[BYTES_W-1:0];
      e.last   = (k == n - 1);
      levels_due.push_back(e);
      w >>= 1;
      h >>= 1;
    end
    return n;
  endfunction

  function automatic logic [DIM_W-1:0] random_dim();
    logic [DIM_W-1:0] d;
    case ($urandom_range(0, 3))
      0:       d = DIM_W'($urandom_range(0, 65535));
      1:       d = DIM_W'($urandom_range(0, 64));
      2:       d = DIM_W'(1) << $urandom_range(0, 15);
      default: d = DIM_W'($urandom_range(0, 4095));
    endcase
    return d;
  endfunction

  function automatic stim_row_t random_request();
    stim_row_t r;
    int sel;
    r = '0;
    r.fmt    = CLASS_W'($urandom_range(0, 7));
    r.width  = random_dim();
    r.height = random_dim();
    sel = $urandom_range(0, 19);
    if (sel == 0) r.count = '0;
    else if (sel == 1) r.count = LVL_W'($urandom_range(LEVEL_CAP + 1, 31));
    else r.count = LVL_W'($urandom_range(1, LEVEL_CAP));
    return r;
  endfunction

  function automatic int pick_pct();
    int p;
    case ($urandom_range(0, 3))
      0:       p = 0;
      1:       p = 10;
      2:       p = 30;
      default: p = 60;
    endcase
    return p;
  endfunction

  // Offer one request and return at the edge that takes it.
  task automatic send_request(input stim_row_t r);
    int first;
    int n;
    in_valid_i     <= 1'b1;
    format_class_i <= r.fmt;
    base_width_i   <= r.width;
    base_height_i  <= r.height;
    level_count_i  <= r.count;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    first = levels_due.size();
    n = mip_chain_layout(r.fmt, r.width, r.height, r.count);
    if (r.typed && n > 0) begin
      levels_due[first].size = r.size0;
      levels_due[levels_due.size() - 1].total = r.total;
    end
    n_requests++;
    if (n == 0) n_zero_count++;
    if (int'(r.count) > LEVEL_CAP) n_saturated++;
  endtask

  task automatic idle_gap(input int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic check_field(input string what, input logic [BYTES_W-1:0] want_v,
                             input logic [BYTES_W-1:0] got_v);
    if (got_v !== want_v) begin
      err_cnt++;
      $display("%0t %s: expected %0d, actual %0d", $time, what, want_v, got_v);
    end
  endtask

  initial begin : drive_requests
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < N_DIRECTED; i++) send_request(dir_rows[i]);
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 40 == 0) begin
        gap_pct   = pick_pct();
        stall_pct = pick_pct();
      end
      // Keep offering while the output is held so the unit backs up.
      if (i == HOLD_AT) begin
        long_hold_req = 1'b1;
        gap_pct = 0;
      end
      if (i == PAUSE_AT) begin
        in_valid_i <= 1'b0;
        while (levels_due.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end
      if (i >= RAND_ITEMS - CALM_ITEMS) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      send_request(random_request());
      if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) idle_gap($urandom_range(1, 19));
    end
    in_valid_i <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d requests across all format classes, %0d with no levels, %0d %s",
             n_requests, n_zero_count, n_saturated, "over the cap");
    $display("checked %0d levels, including a %0d-cycle output hold and a full drain pause",
             n_levels_checked, HOLD_CYCLES);
    if (err_cnt == 0) begin
      $display("mip_level_size_offset_unit: match");
    end else begin
      $display("mip_level_size_offset_unit: mismatch");
    end
    $finish;
  end

  initial begin : stall_results
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left == 0) begin
        if (long_hold_req) begin
          stall_left = HOLD_CYCLES;
          long_hold_req = 1'b0;
        end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
          stall_left = $urandom_range(1, 19);
        end
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_levels
    level_exp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (levels_due.size() == 0) begin
        err_cnt++;
        $display("%0t unexpected level: expected none, actual offset %0d size %0d total %0d",
                 $time, level_offset_o, level_size_o, running_total_o);
      end else begin
        want = levels_due.pop_front();
        check_field("level_offset", want.offset, level_offset_o);
        check_field("level_size", want.size, level_size_o);
        check_field("running_total", want.total, running_total_o);
        check_field("is_last", BYTES_W'(want.last), BYTES_W'(is_last_o));
        n_levels_checked++;
      end
    end
  end

  // Count cycles in which neither channel moves a request or a result.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t no progress for %0d cycles, %0d levels outstanding",
               $time, idle_cycles, levels_due.size());
      $display("mip_level_size_offset_unit: mismatch");
      $finish;
    end
  end

endmodule
